// File: rtl/rdr_pkg.sv
// Shared types and constants for the radial deadzone rescaler.
// Holds the channel payload structs and the queue entry format; no dependencies.
package rdr_pkg;

  localparam int STICK_W      = 16;
  localparam int DZ_W         = 15;
  localparam int MAG_W        = 16;
  localparam int SUM_W        = 32;
  localparam int FULL_LOG2    = 15;
  localparam int AXQ_W        = 17;
  localparam int QUEUE_DEPTH  = 4;

  typedef struct packed {
    logic signed [STICK_W-1:0] stick_x;
    logic signed [STICK_W-1:0] stick_y;
  } in_t;

  typedef struct packed {
    logic signed [STICK_W-1:0] out_x;
    logic signed [STICK_W-1:0] out_y;
    logic                      in_deadzone;
  } out_t;

  typedef struct packed {
    logic             sx;
    logic             sy;
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic [SUM_W-1:0] sum;
  } entry_t;

endpackage

// File: rtl/radial_deadzone_rescale.sv
// Top level of the scaled radial deadzone rescaler for one thumbstick.
// Holds the deadzone register and joins the front queue and back pipeline.
// Depends on rdr_pkg, rdr_front and rdr_back.
//
// Samples arrive on the in_ channel as one struct of stick_x and stick_y and
// transfer at a clock edge where in_valid is high and in_stall is low.
// Results leave on the out_ channel with the same valid and stall rules,
// one result for every sample, in order.
// The deadzone radius is written through cfg_we and cfg_data; the user must
// write it while no sample is in flight, as the block does not enforce this.
// The write takes effect at once. Throughput is one sample per cycle while
// the output is not stalled. An input transfer reaches the result through the
// bit-per-stage square root (16 + RADIUS_FRAC_BITS stages), the remap
// divider (31 + RADIUS_FRAC_BITS stages) and the axis dividers (17 stages).
// A stall on the output freezes the whole back pipeline; the four-entry
// input queue then fills and raises in_stall.
// Reset clears the queue, all valid flags and sets the deadzone to zero.
module radial_deadzone_rescale #(
  parameter int RADIUS_FRAC_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rdr_pkg::in_t             in_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  output rdr_pkg::out_t            out_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  input  logic                     cfg_we,
  input  logic [rdr_pkg::DZ_W-1:0] cfg_data
);

  logic [rdr_pkg::DZ_W-1:0]   dz_r;
  logic [2*rdr_pkg::DZ_W-1:0] dz_sq_r;
  rdr_pkg::entry_t            head;
  logic                       head_valid;
  logic                       pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r    <= '0;
      dz_sq_r <= '0;
    end else if (cfg_we) begin
      dz_r    <= cfg_data;
      dz_sq_r <= (2 * rdr_pkg::DZ_W)'(cfg_data) * (2 * rdr_pkg::DZ_W)'(cfg_data);
    end
  end

  rdr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  rdr_back #(.FRAC(RADIUS_FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .dz         (dz_r),
    .dz_sq      (dz_sq_r),
    .out_data   (out_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

endmodule

// File: rtl/rdr_front.sv
// Front end of the rescaler: takes stick samples, forms magnitudes and the
// sum of squares, and holds them in a short queue. Depends on rdr_pkg.
module rdr_front (
  input  logic            clk,
  input  logic            rst_n,
  input  rdr_pkg::in_t    in_data,
  input  logic            in_valid,
  output logic            in_stall,
  output rdr_pkg::entry_t head,
  output logic            head_valid,
  input  logic            pop
);

  localparam int PW = $clog2(rdr_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(rdr_pkg::QUEUE_DEPTH + 1);

  rdr_pkg::entry_t q_mem [rdr_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push;
  rdr_pkg::entry_t wr_entry;

  always_comb begin
    wr_entry.sx  = in_data.stick_x[rdr_pkg::STICK_W-1];
    wr_entry.sy  = in_data.stick_y[rdr_pkg::STICK_W-1];
    wr_entry.ax  = wr_entry.sx ? rdr_pkg::MAG_W'(-in_data.stick_x)
                               : rdr_pkg::MAG_W'(in_data.stick_x);
    wr_entry.ay  = wr_entry.sy ? rdr_pkg::MAG_W'(-in_data.stick_y)
                               : rdr_pkg::MAG_W'(in_data.stick_y);
    wr_entry.sum = (rdr_pkg::SUM_W'(wr_entry.ax) * rdr_pkg::SUM_W'(wr_entry.ax))
                 + (rdr_pkg::SUM_W'(wr_entry.ay) * rdr_pkg::SUM_W'(wr_entry.ay));
  end

  assign in_stall   = (count_r == CW'(rdr_pkg::QUEUE_DEPTH));
  assign push       = in_valid & ~in_stall;
  assign head_valid = (count_r != '0);
  assign head       = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

// File: rtl/rdr_sqrt_pipe.sv
// Pipelined digit-by-digit integer square root, one result bit per stage.
// Carries side data alongside; advances only on enable. No dependencies.
module rdr_sqrt_pipe #(
  parameter int RW = 24,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] in_rad,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [RW-1:0]   out_root,
  output logic [SW-1:0]   out_side
);

  logic            valid_r [RW];
  logic [RW+1:0]   rem_r   [RW];
  logic [RW-1:0]   root_r  [RW];
  logic [2*RW-1:0] rad_r   [RW];
  logic [SW-1:0]   side_r  [RW];

  for (genvar g = 0; g < RW; g++) begin : g_stage
    logic            v_prev;
    logic [RW+1:0]   rem_prev;
    logic [RW-1:0]   root_prev;
    logic [2*RW-1:0] rad_prev;
    logic [SW-1:0]   side_prev;
    logic [RW+1:0]   rem_sh;
    logic [RW+1:0]   trial;
    logic            ge;

    if (g == 0) begin : g_first
      assign v_prev    = in_valid;
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign rad_prev  = in_rad;
      assign side_prev = in_side;
    end else begin : g_rest
      assign v_prev    = valid_r[g-1];
      assign rem_prev  = rem_r[g-1];
      assign root_prev = root_r[g-1];
      assign rad_prev  = rad_r[g-1];
      assign side_prev = side_r[g-1];
    end

    assign rem_sh = {rem_prev[RW-1:0], rad_prev[2*RW-1 -: 2]};
    assign trial  = {root_prev, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[g] <= 1'b0;
      end else if (en) begin
        valid_r[g] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= ge ? rem_sh - trial : rem_sh;
        root_r[g] <= {root_prev[RW-2:0], ge};
        rad_r[g]  <= rad_prev << 2;
        side_r[g] <= side_prev;
      end
    end
  end

  assign out_valid = valid_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule

// File: rtl/rdr_div_pipe.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
// The starting remainder must be below the divisor. No dependencies.
module rdr_div_pipe #(
  parameter int QW = 39,
  parameter int DW = 16,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_low,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quot,
  output logic [SW-1:0] out_side
);

  logic          valid_r [QW];
  logic [DW-1:0] rem_r   [QW];
  logic [QW-1:0] lq_r    [QW];
  logic [DW-1:0] den_r   [QW];
  logic [SW-1:0] side_r  [QW];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic          v_prev;
    logic [DW-1:0] rem_prev;
    logic [QW-1:0] lq_prev;
    logic [DW-1:0] den_prev;
    logic [SW-1:0] side_prev;
    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;
    logic          ge;

    if (g == 0) begin : g_first
      assign v_prev    = in_valid;
      assign rem_prev  = in_rem;
      assign lq_prev   = in_low;
      assign den_prev  = in_den;
      assign side_prev = in_side;
    end else begin : g_rest
      assign v_prev    = valid_r[g-1];
      assign rem_prev  = rem_r[g-1];
      assign lq_prev   = lq_r[g-1];
      assign den_prev  = den_r[g-1];
      assign side_prev = side_r[g-1];
    end

    assign rem_sh = {rem_prev, lq_prev[QW-1]};
    assign ge     = (rem_sh >= {1'b0, den_prev});
    assign diff   = rem_sh - {1'b0, den_prev};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[g] <= 1'b0;
      end else if (en) begin
        valid_r[g] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
        lq_r[g]   <= {lq_prev[QW-2:0], ge};
        den_r[g]  <= den_prev;
        side_r[g] <= side_prev;
      end
    end
  end

  assign out_valid = valid_r[QW-1];
  assign out_quot  = lq_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

// File: rtl/rdr_back.sv
// Back end of the rescaler: radius, deadzone remap, per-axis rescale and
// saturation in a stall-together pipeline. Depends on rdr_pkg and the
// square root and divider pipelines.
module rdr_back #(
  parameter int FRAC = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rdr_pkg::entry_t            head,
  input  logic                       head_valid,
  output logic                       pop,
  input  logic [rdr_pkg::DZ_W-1:0]   dz,
  input  logic [2*rdr_pkg::DZ_W-1:0] dz_sq,
  output rdr_pkg::out_t              out_data,
  output logic                       out_valid,
  input  logic                       out_stall
);

  localparam int RW   = 16 + FRAC;
  localparam int NQW  = 31 + FRAC;
  localparam int DENW = 16;
  localparam int PRW  = NQW + rdr_pkg::MAG_W;
  localparam int HIW  = PRW - rdr_pkg::AXQ_W;
  localparam logic [RW-1:0]   CAP      = RW'(1) << (rdr_pkg::FULL_LOG2 + FRAC);
  localparam logic [DENW:0]   FULL     = (DENW + 1)'(1) << rdr_pkg::FULL_LOG2;
  localparam logic [rdr_pkg::AXQ_W-1:0] NEG_LIM = rdr_pkg::AXQ_W'(32768);
  localparam logic [rdr_pkg::AXQ_W-1:0] POS_LIM = rdr_pkg::AXQ_W'(32767);
  localparam logic [rdr_pkg::STICK_W-1:0] SAT_NEG = 16'h8000;
  localparam logic [rdr_pkg::STICK_W-1:0] SAT_POS = 16'h7fff;

  typedef struct packed {
    logic                      sx;
    logic                      sy;
    logic [rdr_pkg::MAG_W-1:0] ax;
    logic [rdr_pkg::MAG_W-1:0] ay;
    logic                      dzf;
    logic                      zf;
  } side_t;

  typedef struct packed {
    side_t         s;
    logic [RW-1:0] rr;
  } side_rr_t;

  typedef struct packed {
    logic sx;
    logic ovf;
    logic dzf;
    logic zf;
  } xside_t;

  typedef struct packed {
    logic sy;
    logic ovf;
  } yside_t;

  function automatic logic [rdr_pkg::STICK_W-1:0] sat_axis(
    input logic [rdr_pkg::AXQ_W-1:0] q,
    input logic                      ovf,
    input logic                      neg
  );
    logic [rdr_pkg::STICK_W-1:0] r;
    if (neg) begin
      r = (ovf || q > NEG_LIM) ? SAT_NEG : rdr_pkg::STICK_W'(~q + 1'b1);
    end else begin
      r = (ovf || q > POS_LIM) ? SAT_POS : q[rdr_pkg::STICK_W-1:0];
    end
    return r;
  endfunction

  logic en;
  logic out_valid_r;
  rdr_pkg::out_t out_data_r;

  assign en  = ~out_valid_r | ~out_stall;
  assign pop = en & head_valid;

  logic            b0_valid_r;
  side_t           b0_side_r;
  logic [rdr_pkg::SUM_W-1:0] b0_sum_r;
  logic [2*RW-1:0] b0_rad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_valid_r <= 1'b0;
    end else if (en) begin
      b0_valid_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0_side_r.sx  <= head.sx;
      b0_side_r.sy  <= head.sy;
      b0_side_r.ax  <= head.ax;
      b0_side_r.ay  <= head.ay;
      b0_side_r.dzf <= head.sum < rdr_pkg::SUM_W'(dz_sq);
      b0_side_r.zf  <= head.sum == '0;
      b0_sum_r      <= head.sum;
    end
  end

  assign b0_rad = (2 * RW)'(b0_sum_r) << (2 * FRAC);

  logic          sq_valid;
  logic [RW-1:0] sq_root;
  logic [$bits(side_t)-1:0] sq_side;

  rdr_sqrt_pipe #(.RW(RW), .SW($bits(side_t))) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (b0_valid_r),
    .in_rad    (b0_rad),
    .in_side   (b0_side_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  logic            b1_valid_r;
  side_rr_t        b1_side_r;
  logic [NQW-1:0]  b1_num_r;
  logic [DENW-1:0] b1_den_r;
  logic [RW-1:0]   rc;
  logic [RW-1:0]   rdiff;

  assign rc    = (sq_root > CAP) ? CAP : sq_root;
  assign rdiff = rc - (RW'(dz) << FRAC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r <= 1'b0;
    end else if (en) begin
      b1_valid_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_side_r.s  <= side_t'(sq_side);
      b1_side_r.rr <= sq_root;
      b1_num_r     <= NQW'(rdiff) << rdr_pkg::FULL_LOG2;
      b1_den_r     <= DENW'(FULL - (DENW + 1)'(dz));
    end
  end

  logic           nr_valid;
  logic [NQW-1:0] nr_quot;
  logic [$bits(side_rr_t)-1:0] nr_side;

  rdr_div_pipe #(.QW(NQW), .DW(DENW), .SW($bits(side_rr_t))) u_div_nr (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (b1_valid_r),
    .in_rem    ('0),
    .in_low    (b1_num_r),
    .in_den    (b1_den_r),
    .in_side   (b1_side_r),
    .out_valid (nr_valid),
    .out_quot  (nr_quot),
    .out_side  (nr_side)
  );

  logic           b2_valid_r;
  side_rr_t       b2_side_r;
  side_rr_t       nr_side_s;
  logic [PRW-1:0] b2_px_r;
  logic [PRW-1:0] b2_py_r;

  assign nr_side_s = side_rr_t'(nr_side);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_valid_r <= 1'b0;
    end else if (en) begin
      b2_valid_r <= nr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2_side_r <= nr_side_s;
      b2_px_r   <= PRW'(nr_quot) * PRW'(nr_side_s.s.ax);
      b2_py_r   <= PRW'(nr_quot) * PRW'(nr_side_s.s.ay);
    end
  end

  logic           b3_valid_r;
  xside_t         b3_xs_r;
  yside_t         b3_ys_r;
  logic [RW-1:0]  b3_rr_r;
  logic [RW-1:0]  b3_remx_r;
  logic [RW-1:0]  b3_remy_r;
  logic [rdr_pkg::AXQ_W-1:0] b3_lowx_r;
  logic [rdr_pkg::AXQ_W-1:0] b3_lowy_r;
  logic [HIW-1:0] hix;
  logic [HIW-1:0] hiy;

  assign hix = b2_px_r[PRW-1:rdr_pkg::AXQ_W];
  assign hiy = b2_py_r[PRW-1:rdr_pkg::AXQ_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b3_valid_r <= 1'b0;
    end else if (en) begin
      b3_valid_r <= b2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b3_xs_r.sx  <= b2_side_r.s.sx;
      b3_xs_r.ovf <= hix >= HIW'(b2_side_r.rr);
      b3_xs_r.dzf <= b2_side_r.s.dzf;
      b3_xs_r.zf  <= b2_side_r.s.zf;
      b3_ys_r.sy  <= b2_side_r.s.sy;
      b3_ys_r.ovf <= hiy >= HIW'(b2_side_r.rr);
      b3_rr_r     <= b2_side_r.rr;
      b3_remx_r   <= hix[RW-1:0];
      b3_remy_r   <= hiy[RW-1:0];
      b3_lowx_r   <= b2_px_r[rdr_pkg::AXQ_W-1:0];
      b3_lowy_r   <= b2_py_r[rdr_pkg::AXQ_W-1:0];
    end
  end

  logic dx_valid;
  logic dy_valid;
  logic [rdr_pkg::AXQ_W-1:0] qx;
  logic [rdr_pkg::AXQ_W-1:0] qy;
  logic [$bits(xside_t)-1:0] dx_side;
  logic [$bits(yside_t)-1:0] dy_side;
  xside_t xs;
  yside_t ys;

  rdr_div_pipe #(.QW(rdr_pkg::AXQ_W), .DW(RW), .SW($bits(xside_t))) u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (b3_valid_r),
    .in_rem    (b3_remx_r),
    .in_low    (b3_lowx_r),
    .in_den    (b3_rr_r),
    .in_side   (b3_xs_r),
    .out_valid (dx_valid),
    .out_quot  (qx),
    .out_side  (dx_side)
  );

  rdr_div_pipe #(.QW(rdr_pkg::AXQ_W), .DW(RW), .SW($bits(yside_t))) u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (b3_valid_r),
    .in_rem    (b3_remy_r),
    .in_low    (b3_lowy_r),
    .in_den    (b3_rr_r),
    .in_side   (b3_ys_r),
    .out_valid (dy_valid),
    .out_quot  (qy),
    .out_side  (dy_side)
  );

  assign xs = xside_t'(dx_side);
  assign ys = yside_t'(dy_side);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dx_valid & dy_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (xs.dzf || xs.zf) begin
        out_data_r.out_x <= '0;
        out_data_r.out_y <= '0;
      end else begin
        out_data_r.out_x <= sat_axis(qx, xs.ovf, xs.sx);
        out_data_r.out_y <= sat_axis(qy, ys.ovf, ys.sy);
      end
      out_data_r.in_deadzone <= xs.dzf;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
